// ===== src/crwt_pkg.sv =====
package crwt_pkg;

  localparam int CHAN_W = 8;
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int DIST_W = SQ_W + 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [2:0] {
    REG_SOURCE_RED   = 3'd0,
    REG_SOURCE_GREEN = 3'd1,
    REG_SOURCE_BLUE  = 3'd2,
    REG_TARGET_RED   = 3'd3,
    REG_TARGET_GREEN = 3'd4,
    REG_TARGET_BLUE  = 3'd5,
    REG_MATCH_RADIUS = 3'd6
  } cfg_reg_t;

  // Per-channel partial result handed from the first stage to the second.
  typedef struct packed {
    logic [SQ_W-1:0]   dist_sq;
    logic [CHAN_W-1:0] shifted;
  } lane_t;

endpackage

// ===== src/color_replace_with_tolerance_unit.sv =====
// Color replacement with a Euclidean tolerance. One RGB pixel request is
// accepted per cycle while pixel_stall is low and gives exactly one result
// request, passing through an input register, a stage holding the
// per-channel squared distances and shifted channels, and a result register.
// A pixel whose squared distance to the source color is at most
// match_radius squared is moved by (target - source) per channel, clamped to
// 0..255, and flagged in was_matched; other pixels pass unchanged. Each stage
// holds its data while stalled and refills as soon as the stage ahead frees,
// so stalls on the output propagate back to pixel_stall without loss.
// Write configuration registers only while no pixel is in flight; writes to
// indexes beyond match_radius are ignored.
module color_replace_with_tolerance_unit
  import crwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [CHAN_W-1:0] pixel_red,
  input  logic [CHAN_W-1:0] pixel_green,
  input  logic [CHAN_W-1:0] pixel_blue,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAN_W-1:0] result_red,
  output logic [CHAN_W-1:0] result_green,
  output logic [CHAN_W-1:0] result_blue,
  output logic              was_matched,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CHAN_W-1:0] cfg_data
);

  logic [CHAN_W-1:0] source_red, source_green, source_blue;
  logic [CHAN_W-1:0] target_red, target_green, target_blue;
  logic [CHAN_W-1:0] match_radius;
  logic [SQ_W-1:0]   radius_sq;

  logic              in_valid;
  logic [CHAN_W-1:0] in_red, in_green, in_blue;

  logic              mid_valid;
  logic [CHAN_W-1:0] mid_red, mid_green, mid_blue;
  lane_t             mid_lane_r, mid_lane_g, mid_lane_b;

  lane_t             lane_r, lane_g, lane_b;
  logic [DIST_W-1:0] dist_total;
  logic              matched;

  logic out_adv, mid_adv, in_adv;

  assign cfg_ready   = 1'b1;
  assign out_adv     = !result_valid || !result_stall;
  assign mid_adv     = !mid_valid || out_adv;
  assign in_adv      = !in_valid || mid_adv;
  assign pixel_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_red   <= '0;
      source_green <= '0;
      source_blue  <= '0;
      target_red   <= '0;
      target_green <= '0;
      target_blue  <= '0;
      match_radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_RED:   source_red   <= cfg_data;
        REG_SOURCE_GREEN: source_green <= cfg_data;
        REG_SOURCE_BLUE:  source_blue  <= cfg_data;
        REG_TARGET_RED:   target_red   <= cfg_data;
        REG_TARGET_GREEN: target_green <= cfg_data;
        REG_TARGET_BLUE:  target_blue  <= cfg_data;
        REG_MATCH_RADIUS: match_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bound is registered from the radius register and follows it in the cycle after.
  always_ff @(posedge clk) begin
    radius_sq <= SQ_W'(match_radius) * SQ_W'(match_radius);
  end

  crwt_lane u_lane_r (.pix(in_red),   .src(source_red),   .dst(target_red),   .lane(lane_r));
  crwt_lane u_lane_g (.pix(in_green), .src(source_green), .dst(target_green), .lane(lane_g));
  crwt_lane u_lane_b (.pix(in_blue),  .src(source_blue),  .dst(target_blue),  .lane(lane_b));

  always_comb begin
    dist_total = DIST_W'(mid_lane_r.dist_sq) + DIST_W'(mid_lane_g.dist_sq)
               + DIST_W'(mid_lane_b.dist_sq);
    matched    = dist_total <= DIST_W'(radius_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      mid_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid <= pixel_valid;
      end
      if (mid_adv) begin
        mid_valid <= in_valid;
      end
      if (out_adv) begin
        result_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && pixel_valid) begin
      in_red   <= pixel_red;
      in_green <= pixel_green;
      in_blue  <= pixel_blue;
    end
    if (mid_adv && in_valid) begin
      mid_red    <= in_red;
      mid_green  <= in_green;
      mid_blue   <= in_blue;
      mid_lane_r <= lane_r;
      mid_lane_g <= lane_g;
      mid_lane_b <= lane_b;
    end
    if (out_adv && mid_valid) begin
      was_matched  <= matched;
      result_red   <= matched ? mid_lane_r.shifted : mid_red;
      result_green <= matched ? mid_lane_g.shifted : mid_green;
      result_blue  <= matched ? mid_lane_b.shifted : mid_blue;
    end
  end

endmodule

// ===== src/crwt_lane.sv =====
module crwt_lane
  import crwt_pkg::*;
(
  input  logic [CHAN_W-1:0] pix,
  input  logic [CHAN_W-1:0] src,
  input  logic [CHAN_W-1:0] dst,
  output lane_t             lane
);

  logic [CHAN_W-1:0] diff;
  logic [CHAN_W+1:0] sum;

  always_comb begin
    diff = (pix >= src) ? (pix - src) : (src - pix);
    // pix + dst - src lies in -255..510; bit 9 flags negative, bit 8 overflow
    sum  = {2'b00, pix} + {2'b00, dst} - {2'b00, src};
    lane.dist_sq = SQ_W'(diff) * SQ_W'(diff);
    if (sum[CHAN_W+1]) begin
      lane.shifted = '0;
    end else if (sum[CHAN_W]) begin
      lane.shifted = CHAN_MAX;
    end else begin
      lane.shifted = sum[CHAN_W-1:0];
    end
  end

endmodule

// ===== src/crwt_checker.sv =====
module crwt_checker
  import crwt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pixel_valid,
  input logic              pixel_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic [CHAN_W-1:0] result_red,
  input logic [CHAN_W-1:0] result_green,
  input logic [CHAN_W-1:0] result_blue,
  input logic              was_matched
);

  // Hold a stalled result and its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_red)
      && $stable(result_green) && $stable(result_blue) && $stable(was_matched))
    else $error("stalled result changed");

  // Back-pressure on the pixel side only when the pipeline is full and blocked.
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("pixel stalled without a blocked result");

  // An accepted pixel reaches the output while the output is not stalled.
  assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("accepted pixel did not reach the output");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind color_replace_with_tolerance_unit crwt_checker u_crwt_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import crwt_pkg::*;

  localparam int NUM_REGS        = 7;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 9;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 40;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   matched;
  } recolor_t;

  typedef struct packed {
    logic [2:0]        idx;
    logic [CHAN_W-1:0] data;
  } reg_write_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              pixel_valid  = 1'b0;
  logic              pixel_stall;
  logic [CHAN_W-1:0] pixel_red    = '0;
  logic [CHAN_W-1:0] pixel_green  = '0;
  logic [CHAN_W-1:0] pixel_blue   = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [CHAN_W-1:0] result_red;
  logic [CHAN_W-1:0] result_green;
  logic [CHAN_W-1:0] result_blue;
  logic              was_matched;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index    = '0;
  logic [CHAN_W-1:0] cfg_data     = '0;

  logic [CHAN_W-1:0] color_regs [NUM_REGS];
  pixel_t            pending_pixels[$];
  recolor_t          expected_recolors[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          gap_max     = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  bit          hold_armed  = 1'b0;

  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  color_replace_with_tolerance_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_red   (result_red),
    .result_green (result_green),
    .result_blue  (result_blue),
    .was_matched  (was_matched),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int chan_dist_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic logic [CHAN_W-1:0] shift_chan(logic [CHAN_W-1:0] pix,
                                                   logic [CHAN_W-1:0] src,
                                                   logic [CHAN_W-1:0] tgt);
    int v;
    v = int'(pix) + int'(tgt) - int'(src);
    if (v < 0) return '0;
    if (v > int'(CHAN_MAX)) return CHAN_MAX;
    return v[CHAN_W-1:0];
  endfunction

  function automatic recolor_t recolor(pixel_t p);
    recolor_t r;
    int dist_total;
    int bound;
    dist_total = chan_dist_sq(p.red,   color_regs[REG_SOURCE_RED])
               + chan_dist_sq(p.green, color_regs[REG_SOURCE_GREEN])
               + chan_dist_sq(p.blue,  color_regs[REG_SOURCE_BLUE]);
    bound = int'(color_regs[REG_MATCH_RADIUS]) * int'(color_regs[REG_MATCH_RADIUS]);
    r.matched = (dist_total <= bound);
    if (r.matched) begin
      r.pix.red   = shift_chan(p.red,   color_regs[REG_SOURCE_RED],   color_regs[REG_TARGET_RED]);
      r.pix.green = shift_chan(p.green, color_regs[REG_SOURCE_GREEN], color_regs[REG_TARGET_GREEN]);
      r.pix.blue  = shift_chan(p.blue,  color_regs[REG_SOURCE_BLUE],  color_regs[REG_TARGET_BLUE]);
    end else begin
      r.pix = p;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Pixel driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : pixel_driver
    pixel_t next_pix;
    if (rst) begin
      pixel_valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (pixel_valid && !pixel_stall)
        expected_recolors.push_back(recolor({pixel_red, pixel_green, pixel_blue}));
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          pixel_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_pix    = pending_pixels.pop_front();
          pixel_valid <= 1'b1;
          pixel_red   <= next_pix.red;
          pixel_green <= next_pix.green;
          pixel_blue  <= next_pix.blue;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern, with one long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:    result_stall <= 1'b0;
        STALL_RANDOM:  result_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: result_stall <= ((cycle_count % 7) < 3);
        default:       result_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    recolor_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_recolors.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d matched %0b",
                                  result_red, result_green, result_blue, was_matched));
      end else begin
        want = expected_recolors.pop_front();
        if (result_red !== want.pix.red)
          report_mismatch($sformatf("result_red %0d, want %0d", result_red, want.pix.red));
        if (result_green !== want.pix.green)
          report_mismatch($sformatf("result_green %0d, want %0d", result_green, want.pix.green));
        if (result_blue !== want.pix.blue)
          report_mismatch($sformatf("result_blue %0d, want %0d", result_blue, want.pix.blue));
        if (was_matched !== want.matched)
          report_mismatch($sformatf("was_matched %0b, want %0b", was_matched, want.matched));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                      logic [CHAN_W-1:0] b);
    pending_pixels.push_back({r, g, b});
  endtask

  // Return aligned to a rising edge once no request is pending or in flight.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || pixel_valid || expected_recolors.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_regs(input reg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].idx;
      cfg_data  <= writes[i].data;
      do @(posedge clk);
      while (!cfg_ready);
      if (writes[i].idx < NUM_REGS) color_regs[writes[i].idx] = writes[i].data;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_color_map(input pixel_t src, pixel_t tgt,
                               logic [CHAN_W-1:0] radius, bit poke_unused);
    reg_write_t w[$];
    w.push_back('{idx: REG_SOURCE_RED,   data: src.red});
    w.push_back('{idx: REG_SOURCE_GREEN, data: src.green});
    w.push_back('{idx: REG_SOURCE_BLUE,  data: src.blue});
    w.push_back('{idx: REG_TARGET_RED,   data: tgt.red});
    w.push_back('{idx: REG_TARGET_GREEN, data: tgt.green});
    w.push_back('{idx: REG_TARGET_BLUE,  data: tgt.blue});
    w.push_back('{idx: REG_MATCH_RADIUS, data: radius});
    // Out-of-range index must leave every register alone.
    if (poke_unused) w.push_back('{idx: REG_UNUSED, data: CHAN_W'($urandom)});
    write_regs(w);
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] near_chan(logic [CHAN_W-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  initial begin : stimulus
    pixel_t src;
    pixel_t tgt;
    logic [CHAN_W-1:0] radius;
    int spread;

    foreach (color_regs[i]) color_regs[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: only black matches, and maps to black.
    send(8'd0, 8'd0, 8'd0);
    send(8'd0, 8'd0, 8'd1);
    send(8'd255, 8'd255, 8'd255);
    wait_idle();

    // Boundary of tolerance and clamp at the top.
    set_color_map({8'd100, 8'd150, 8'd200}, {8'd250, 8'd10, 8'd128}, 8'd10, 1'b1);
    send(8'd100, 8'd150, 8'd200);
    send(8'd110, 8'd150, 8'd200);
    send(8'd106, 8'd158, 8'd200);
    send(8'd111, 8'd150, 8'd200);
    send(8'd100, 8'd150, 8'd189);
    send(8'd91, 8'd150, 8'd200);
    wait_idle();

    // Clamp at both ends within one pixel.
    stall_mode = STALL_RANDOM;
    set_color_map({8'd5, 8'd250, 8'd0}, {8'd250, 8'd5, 8'd255}, 8'd30, 1'b0);
    send(8'd20, 8'd235, 8'd0);
    send(8'd0, 8'd255, 8'd0);
    send(8'd0, 8'd0, 8'd0);
    wait_idle();

    // Largest radius.
    set_color_map({8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 8'd255, 1'b0);
    send(8'd255, 8'd0, 8'd0);
    send(8'd147, 8'd147, 8'd147);
    send(8'd148, 8'd148, 8'd148);
    send(8'd255, 8'd255, 8'd255);
    send(8'd0, 8'd255, 8'd0);
    wait_idle();

    // Zero radius: exact source only, moved exactly onto the target.
    set_color_map({8'd37, 8'd200, 8'd255}, {8'd199, 8'd3, 8'd64}, 8'd0, 1'b1);
    send(8'd37, 8'd200, 8'd255);
    send(8'd38, 8'd200, 8'd255);
    send(8'd37, 8'd200, 8'd254);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      src = {rand_chan(), rand_chan(), rand_chan()};
      tgt = {rand_chan(), rand_chan(), rand_chan()};
      case ($urandom_range(0, 4))
        0:       radius = '0;
        1:       radius = CHAN_MAX;
        2:       radius = CHAN_W'($urandom_range(1, 8));
        default: radius = CHAN_W'($urandom_range(0, 255));
      endcase
      set_color_map(src, tgt, radius, 1'($urandom_range(0, 1)));
      stall_mode = stall_mode_t'(ph % 4);
      gap_max    = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
      if (ph == PRESSURE_PHASE) begin
        // Hold the output off while requests keep coming.
        gap_max    = 0;
        hold_armed = 1'b1;
      end
      spread = int'(radius) + 1;
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        if ($urandom_range(0, 9) < 6)
          send(near_chan(src.red, spread), near_chan(src.green, spread),
               near_chan(src.blue, spread));
        else
          send(rand_chan(), rand_chan(), rand_chan());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/crwt_pkg.sv
src/crwt_lane.sv
src/color_replace_with_tolerance_unit.sv
src/crwt_checker.sv
dv/tb_top.sv
